>>> hdl/wis_pkg.sv
`timescale 1ns / 1ps

package wis_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 1024;
	localparam int WEIGHT_BITS = 25;

	// Fixed field widths of the transaction payloads
	localparam int ENTRY_W = 25;
	localparam int HASH_W  = 64;

	// Derived widths
	localparam int IDX_W     = $clog2(MAX_ENTRIES);
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W     = WEIGHT_BITS + IDX_W;
	localparam int DIV_CNT_W = $clog2(HASH_W);

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_SELECT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_TOTAL = 2'd1,
		ST_FULL       = 2'd2
	} status_t;

endpackage

>>> hdl/wis_in_if.sv
`timescale 1ns / 1ps

interface wis_in_if
	import wis_pkg::*;
();
	logic               valid;
	logic               ready;
	opcode_t            opcode;
	logic [ENTRY_W-1:0] entry_weight;
	logic [HASH_W-1:0]  hash_value;

	modport source (output valid, opcode, entry_weight, hash_value, input ready);
	modport sink   (input valid, opcode, entry_weight, hash_value, output ready);
endinterface

>>> hdl/wis_out_if.sv
`timescale 1ns / 1ps

interface wis_out_if
	import wis_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] chosen_index;
	status_t          status;

	modport source (output valid, chosen_index, status, input ready);
	modport sink   (input valid, chosen_index, status, output ready);
endinterface

>>> hdl/wis_ram.sv
`timescale 1ns / 1ps

module wis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/weighted_index_select.sv
`timescale 1ns / 1ps
// An append, or a select on an empty or zero-weight table, is answered in the cycle after
// its transaction is taken; any other select first divides, then walks the table, then responds.
// One transaction at a time is taken; such a select runs the 64-step restoring modulo unit,
// followed by a scan of the weight RAM at one entry per cycle, before it responds.
// Reset clears the entry count, the running total and all control state; the weight RAM keeps
// no reset value and needs no clearing pass, as only data of written entries is ever used.

module weighted_index_select
	import wis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	wis_in_if.sink    req,
	wis_out_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WALK,
		S_RESP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [TOT_W-1:0]     total_q;
	logic [TOT_W-1:0]     rem_q;
	logic [HASH_W-1:0]    hash_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 rsp_valid_q;
	logic [IDX_W-1:0]     rsp_idx_q;
	status_t              rsp_status_q;

	logic                   req_accept;
	logic                   slot_free;
	logic                   table_full;
	logic [WEIGHT_BITS-1:0] new_weight;
	logic                   ram_wr_en;
	logic [IDX_W-1:0]       ram_rd_addr;
	logic [WEIGHT_BITS-1:0] ram_rd_data;
	logic [TOT_W:0]         div_trial;
	logic [TOT_W:0]         div_diff;
	logic [TOT_W-1:0]       div_next;
	logic                   walk_hit;
	logic                   walk_last;

	// The output register is free when it is empty or its transaction completes this cycle.
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE) && slot_free;
	assign req_accept = req.valid && req.ready;

	assign table_full = (count_q == CNT_W'(MAX_ENTRIES));
	assign new_weight = WEIGHT_BITS'(req.entry_weight);
	assign ram_wr_en  = req_accept && (req.opcode == OP_APPEND) && !table_full;

	// During the walk the RAM is always one entry ahead of the compare, so the entry
	// being compared is read back just as it is needed. Outside the walk address zero
	// is presented, which primes the first compare on the cycle the division ends.
	assign ram_rd_addr = (state_q == S_WALK) ? (idx_q + IDX_W'(1)) : '0;

	wis_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (MAX_ENTRIES)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (new_weight),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// One restoring division step: bring in the next hash bit and subtract the total if
	// it fits. The partial remainder stays below the total, so it fits in TOT_W bits.
	assign div_trial = {rem_q, hash_q[HASH_W-1]};
	assign div_diff  = div_trial - {1'b0, total_q};
	assign div_next  = (div_trial >= {1'b0, total_q}) ? div_diff[TOT_W-1:0]
	                                                   : div_trial[TOT_W-1:0];

	// The walk stops at the first entry whose weight exceeds what is left of the remainder.
	// Reaching the last entry also ends it; with a consistent total that entry is the hit.
	assign walk_hit  = rem_q < TOT_W'(ram_rd_data);
	assign walk_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			total_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_idx_q    <= '0;
			rsp_status_q <= ST_OK;
			rem_q        <= '0;
			hash_q       <= '0;
			div_cnt_q    <= '0;
			idx_q        <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						if (req.opcode == OP_APPEND) begin
							rsp_valid_q <= 1'b1;
							if (table_full) begin
								rsp_idx_q    <= '0;
								rsp_status_q <= ST_FULL;
							end else begin
								rsp_idx_q    <= count_q[IDX_W-1:0];
								rsp_status_q <= ST_OK;
								count_q      <= count_q + CNT_W'(1);
								total_q      <= total_q + TOT_W'(new_weight);
							end
						end else if ((total_q == '0) || (count_q == '0)) begin
							rsp_valid_q  <= 1'b1;
							rsp_idx_q    <= '0;
							rsp_status_q <= ST_ZERO_TOTAL;
						end else begin
							hash_q    <= req.hash_value;
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q     <= div_next;
					hash_q    <= {hash_q[HASH_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(HASH_W - 1)) begin
						idx_q   <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_hit || walk_last) begin
						state_q <= S_RESP;
					end else begin
						rem_q <= rem_q - TOT_W'(ram_rd_data);
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_RESP: begin
					if (slot_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_idx_q    <= idx_q;
						rsp_status_q <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.chosen_index = rsp_idx_q;
	assign rsp.status       = rsp_status_q;

`ifndef NO_ASSERTIONS
	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	// An empty table has no weight.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("non-zero total on empty table");

	// The walk only runs over a non-empty table with a non-zero total, inside the table.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((total_q != '0) && (CNT_W'(idx_q) < count_q)))
		else $error("walk outside written entries");

	// A successful result always names an entry that has been written.
	a_ok_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == ST_OK)) |-> (CNT_W'(rsp_idx_q) < count_q))
		else $error("result index beyond entry count");
`endif

endmodule
